FILE: hw/rtl/mtk_pkg.sv
// Shared types, codes and constant functions of the Morse tone keyer.
// No dependencies; used by every file of the block but mtk_ram.
package mtk_pkg;

	localparam int SINE_ENTRIES_DEF = 1024;
	localparam int TEXT_DEPTH_DEF   = 256;
	localparam int RAMP_STEPS_DEF   = 100;

	localparam int DIT_W    = 20;
	localparam int PHASE_W  = 32;
	localparam int CFG_W    = 32;
	localparam int COUNT_W  = 23;
	localparam int ENV_W    = 7;
	localparam int SHAPE_W  = 15;
	localparam int SAMPLE_W = 16;
	localparam int CHAR_W   = 8;

	localparam logic [SHAPE_W-1:0] SHAPE_FULL = 15'd32767;
	localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_SPARE  = 2'd3
	} req_t;

	typedef enum logic [0:0] {
		CFG_DIT  = 1'b0,
		CFG_STEP = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] len;
		logic [5:0] pat;
	} morse_t;

	function automatic morse_t morse_lookup(input logic [CHAR_W-1:0] c_in);
		logic [CHAR_W-1:0] c;
		morse_t m;
		c = c_in;
		if (c >= 8'h61 && c <= 8'h7a) begin
			c = c - 8'd32;
		end
		unique case (c)
			"A": m = '{3'd2, 6'd1};
			"B": m = '{3'd4, 6'd8};
			"C": m = '{3'd4, 6'd10};
			"D": m = '{3'd3, 6'd4};
			"E": m = '{3'd1, 6'd0};
			"F": m = '{3'd4, 6'd2};
			"G": m = '{3'd3, 6'd6};
			"H": m = '{3'd4, 6'd0};
			"I": m = '{3'd2, 6'd0};
			"J": m = '{3'd4, 6'd7};
			"K": m = '{3'd3, 6'd5};
			"L": m = '{3'd4, 6'd4};
			"M": m = '{3'd2, 6'd3};
			"N": m = '{3'd2, 6'd2};
			"O": m = '{3'd3, 6'd7};
			"P": m = '{3'd4, 6'd6};
			"Q": m = '{3'd4, 6'd13};
			"R": m = '{3'd3, 6'd2};
			"S": m = '{3'd3, 6'd0};
			"T": m = '{3'd1, 6'd1};
			"U": m = '{3'd3, 6'd1};
			"V": m = '{3'd4, 6'd1};
			"W": m = '{3'd3, 6'd3};
			"X": m = '{3'd4, 6'd9};
			"Y": m = '{3'd4, 6'd11};
			"Z": m = '{3'd4, 6'd12};
			"0": m = '{3'd5, 6'd31};
			"1": m = '{3'd5, 6'd15};
			"2": m = '{3'd5, 6'd7};
			"3": m = '{3'd5, 6'd3};
			"4": m = '{3'd5, 6'd1};
			"5": m = '{3'd5, 6'd0};
			"6": m = '{3'd5, 6'd16};
			"7": m = '{3'd5, 6'd24};
			"8": m = '{3'd5, 6'd28};
			"9": m = '{3'd5, 6'd30};
			".": m = '{3'd6, 6'd21};
			",": m = '{3'd6, 6'd51};
			"?": m = '{3'd6, 6'd12};
			"/": m = '{3'd5, 6'd18};
			"=": m = '{3'd5, 6'd17};
			"-": m = '{3'd6, 6'd33};
			":": m = '{3'd6, 6'd56};
			"(": m = '{3'd5, 6'd22};
			")": m = '{3'd6, 6'd45};
			default: m = '{3'd0, 6'd0};
		endcase
		return m;
	endfunction

	function automatic logic [SHAPE_W-1:0] ramp_shape(input int pos);
		int h;
		int v;
		h = pos >> 1;
		v = 18307 + h * (-18023 + h * (11090 + h * -148));
		if (v < 0) begin
			v = 0;
		end
		return SHAPE_W'(v >>> 8);
	endfunction

	function automatic logic [SHAPE_W-1:0] sine_mag(input int j, input real step);
		real a;
		a = 32767.0 * $sin(step * j);
		return SHAPE_W'($rtoi(a + 0.5));
	endfunction

endpackage

FILE: hw/rtl/mtk_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module mtk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/mtk_tone.sv
// Quarter-wave sine oscillator lookup and envelope multiply, two stages.
// Depends on mtk_pkg for widths and the sine table function.
module mtk_tone #(
	parameter int SINE_ENTRIES = mtk_pkg::SINE_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic [mtk_pkg::PHASE_W-1:0]          phase,
	input  logic [mtk_pkg::SHAPE_W-1:0]          shape,
	output logic signed [mtk_pkg::SAMPLE_W-1:0]  sample
);

	localparam int  LOG2N      = $clog2(SINE_ENTRIES);
	localparam int  QN         = SINE_ENTRIES / 4;
	localparam int  QW         = $clog2(QN + 1);
	localparam int  JW         = LOG2N - 2;
	localparam real ANGLE_STEP = 6.283185307179586 / SINE_ENTRIES;

	logic [mtk_pkg::SHAPE_W-1:0] quarter_tab [QN+1];

	for (genvar gi = 0; gi <= QN; gi++) begin : g_tab
		assign quarter_tab[gi] = mtk_pkg::sine_mag(gi, ANGLE_STEP);
	end

	logic [1:0]                  quad;
	logic [JW-1:0]               j;
	logic [QW-1:0]               jq;
	logic [mtk_pkg::SHAPE_W-1:0] mag_s1;
	logic                        neg_s1;
	logic [mtk_pkg::SHAPE_W-1:0] shape_s1;
	logic signed [15:0]          sine;
	logic signed [31:0]          prod_s2;

	assign quad = phase[31:30];
	assign j    = phase[29 -: JW];
	assign jq   = quad[0] ? (QW'(QN) - QW'(j)) : QW'(j);
	assign sine = neg_s1 ? -$signed({1'b0, mag_s1}) : $signed({1'b0, mag_s1});

	always_ff @(posedge clk) begin
		mag_s1   <= quarter_tab[jq];
		neg_s1   <= quad[1];
		shape_s1 <= shape;
		prod_s2  <= sine * $signed({1'b0, shape_s1});
	end

	assign sample = prod_s2[30:15];

endmodule

FILE: hw/rtl/morse_tone_keyer_top.sv
// Morse tone keyer: text buffer in RAM, letter sequencer, shaped sine output.
// Depends on mtk_pkg, mtk_ram and mtk_tone.
// One word is in flight at a time. Append, clear and unused words are taken in S_IDLE;
// a tick runs S_SAMPLE, S_MUL and S_OUT, after any of S_ELEM to start an element, S_FETCH
// and S_LOOK per character read, S_SPACE for the word-space check, S_FETCH at text end.
// Reset clears the keyer state and sets default dit and step at once; text RAM needs no pass.
module morse_tone_keyer_top #(
	parameter int SINE_ENTRIES = mtk_pkg::SINE_ENTRIES_DEF,
	parameter int TEXT_DEPTH   = mtk_pkg::TEXT_DEPTH_DEF,
	parameter int RAMP_STEPS   = mtk_pkg::RAMP_STEPS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // char_code
	input  logic [1:0]                s_tuser,  // req_type
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,  // sample[15:0], done_res[16]
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_addr,
	input  logic [mtk_pkg::CFG_W-1:0] cfg_data
);

	localparam int LW = $clog2(TEXT_DEPTH + 1);
	localparam int IW = $clog2(TEXT_DEPTH);
	localparam int EW = mtk_pkg::ENV_W;
	localparam int CW = mtk_pkg::COUNT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_LOOK, S_ELEM, S_SPACE, S_SAMPLE, S_MUL, S_OUT
	} state_t;

	state_t                       state_q;
	logic [mtk_pkg::DIT_W-1:0]    dit_q;
	logic [mtk_pkg::PHASE_W-1:0]  step_q;
	logic [mtk_pkg::PHASE_W-1:0]  phase_q;
	logic [EW-1:0]                env_q;
	logic [CW-1:0]                tone_q;
	logic [CW-1:0]                gap_q;
	logic [5:0]                   pel_q;
	logic [2:0]                   plen_q;
	logic [LW-1:0]                len_q;
	logic [LW-1:0]                cursor_q;
	logic                         fin_q;
	logic                         m_tvalid_q;
	logic [23:0]                  m_tdata_q;
	logic [16:0]                  res_q;
	logic                         wait_q;

	logic [7:0]                   rdata;
	logic                         ram_we;
	logic [mtk_pkg::SHAPE_W-1:0]  ramp_tab [2**EW];
	logic [mtk_pkg::SHAPE_W-1:0]  shape;
	logic signed [15:0]           tone_sample;
	mtk_pkg::morse_t              code;
	logic [CW-1:0]                dit1, dit3, dit7;
	logic [2:0]                   plen_n;
	logic                         dash;
	mtk_pkg::req_t                req;

	for (genvar gi = 0; gi < 2**EW; gi++) begin : g_ramp
		assign ramp_tab[gi] = mtk_pkg::ramp_shape(gi);
	end

	assign req      = mtk_pkg::req_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign ram_we   = s_tvalid && s_tready && req == mtk_pkg::REQ_APPEND
		&& len_q < LW'(TEXT_DEPTH);
	assign code     = mtk_pkg::morse_lookup(rdata);
	assign dit1     = CW'(dit_q);
	assign dit3     = dit1 + (dit1 << 1);
	assign dit7     = (dit1 << 3) - dit1;
	assign plen_n   = plen_q - 3'd1;
	assign dash     = pel_q[plen_n];

	always_comb begin
		shape = '0;
		if (tone_q != '0) begin
			shape = (env_q >= EW'(RAMP_STEPS)) ? mtk_pkg::SHAPE_FULL : ramp_tab[env_q];
		end else if (gap_q != '0 && env_q != '0) begin
			shape = ramp_tab[env_q];
		end
	end

	mtk_ram #(.WIDTH(mtk_pkg::CHAR_W), .DEPTH(TEXT_DEPTH)) u_text (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[IW-1:0]),
		.wdata (s_tdata),
		.raddr (cursor_q[IW-1:0]),
		.rdata (rdata)
	);

	mtk_tone #(.SINE_ENTRIES(SINE_ENTRIES)) u_tone (
		.clk    (clk),
		.phase  (phase_q),
		.shape  (shape),
		.sample (tone_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dit_q      <= 20'd2880;
			step_q     <= 32'd62634975;
			phase_q    <= '0;
			env_q      <= '0;
			tone_q     <= '0;
			gap_q      <= '0;
			pel_q      <= '0;
			plen_q     <= '0;
			len_q      <= '0;
			cursor_q   <= '0;
			fin_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			wait_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (mtk_pkg::cfg_idx_t'(cfg_addr))
					mtk_pkg::CFG_DIT:  dit_q  <= cfg_data[mtk_pkg::DIT_W-1:0];
					mtk_pkg::CFG_STEP: step_q <= cfg_data;
				endcase
			end
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						unique case (req)
							mtk_pkg::REQ_APPEND: begin
								if (len_q < LW'(TEXT_DEPTH)) begin
									len_q <= len_q + LW'(1);
								end
								fin_q <= 1'b0;
							end
							mtk_pkg::REQ_CLEAR: begin
								len_q    <= '0;
								cursor_q <= '0;
								fin_q    <= 1'b0;
							end
							mtk_pkg::REQ_TICK: begin
								if (tone_q == '0 && gap_q == '0) begin
									state_q <= (plen_q == '0) ? S_FETCH : S_ELEM;
								end else begin
									state_q <= S_SAMPLE;
								end
							end
							default: ;
						endcase
					end
				end
				S_FETCH: begin
					if (cursor_q < len_q) begin
						cursor_q <= cursor_q + LW'(1);
						state_q  <= S_LOOK;
					end else begin
						tone_q  <= '0;
						gap_q   <= CW'(1);
						fin_q   <= 1'b1;
						state_q <= S_SAMPLE;
					end
				end
				S_LOOK: begin
					if (code.len != '0) begin
						plen_q  <= code.len;
						pel_q   <= code.pat;
						state_q <= S_ELEM;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_ELEM: begin
					plen_q <= plen_n;
					pel_q  <= pel_q & ((6'd1 << plen_n) - 6'd1);
					tone_q <= dash ? dit3 : dit1;
					if (plen_n != '0) begin
						gap_q   <= dit1;
						state_q <= S_SAMPLE;
					end else if (cursor_q < len_q) begin
						state_q <= S_SPACE;
					end else begin
						gap_q   <= dit3;
						state_q <= S_SAMPLE;
					end
				end
				S_SPACE: begin
					if (rdata == mtk_pkg::SPACE_CHAR) begin
						gap_q    <= dit7;
						cursor_q <= cursor_q + LW'(1);
					end else begin
						gap_q <= dit3;
					end
					state_q <= S_SAMPLE;
				end
				S_SAMPLE: begin
					phase_q <= phase_q + step_q;
					if (tone_q != '0) begin
						tone_q <= tone_q - CW'(1);
						if (env_q < EW'(RAMP_STEPS)) begin
							env_q <= env_q + EW'(1);
						end
					end else if (gap_q != '0) begin
						gap_q <= gap_q - CW'(1);
						if (env_q != '0) begin
							env_q <= env_q - EW'(1);
						end
					end
					wait_q  <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (wait_q) begin
						state_q <= S_OUT;
					end
					wait_q <= 1'b1;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL && wait_q) begin
			res_q <= {fin_q, tone_sample};
		end
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {7'd0, res_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= len_q)
		else $error("read cursor passed the text length");
	a_env: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= EW'(RAMP_STEPS))
		else $error("envelope position beyond ramp length");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("output word raised outside the output state");
`endif

endmodule

FILE: test/tb_checker.sv
// Checker of the Morse tone keyer: watches the input, output and register channels,
// predicts every tick sample and compares it. Depends on mtk_pkg for request and
// register codes.
module tb_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [7:0]                s_tdata,
	input  logic [1:0]                s_tuser,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [23:0]               m_tdata,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_addr,
	input  logic [mtk_pkg::CFG_W-1:0] cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        samples_checked,
	output int                        words_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import mtk_pkg::*;

	localparam int WAVE_LEN = 1024;
	localparam int BUF_LEN  = 256;
	localparam int RAMP_LEN = 100;

	typedef struct {
		logic signed [15:0] smp;
		logic               done;
	} tone_word_t;

	tone_word_t         tone_fifo[$];
	logic signed [15:0] wave[WAVE_LEN];
	string              glyph[128];
	logic [7:0]         txt[BUF_LEN];

	logic [19:0] dit_len;
	logic [31:0] step;
	logic [31:0] phase;
	logic [6:0]  env_pos;
	logic [22:0] tone_left;
	logic [22:0] gap_left;
	string       letter;
	int          elem_left;
	int          txt_len;
	int          cursor;
	logic        finished;

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] sin_q62(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] sum;
		logic [63:0] term;
		x2 = mul_q62(x, x);
		sum = x;
		term = x;
		for (int k = 1; k <= 20 && term != 0; k++) begin
			term = mul_q62(term, x2) / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic int ramp(input int pos);
		int h;
		int v;
		h = pos / 2;
		v = 18307 + h * (-18023 + h * (11090 + h * -148));
		if (v < 0) begin
			v = 0;
		end
		return v >>> 8;
	endfunction

	function automatic string glyph_of(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (u >= "a" && u <= "z") begin
			u = u - 8'd32;
		end
		if (u >= 8'd128) begin
			return "";
		end
		return glyph[u[6:0]];
	endfunction

	initial begin
		logic [63:0] unit;
		logic [63:0] mag;
		int quad;
		int rem;
		unit = 64'h6487ED5110B4611A / WAVE_LEN;
		for (int i = 0; i < WAVE_LEN; i++) begin
			quad = (4 * i) / WAVE_LEN;
			rem = (4 * i) % WAVE_LEN;
			if (quad % 2 == 1) begin
				rem = WAVE_LEN - rem;
			end
			mag = ((sin_q62(unit * rem) >> 20) * 32767 + (64'd1 << 41)) >> 42;
			wave[i] = (quad >= 2) ? -16'(mag) : 16'(mag);
		end
		foreach (glyph[i]) begin
			glyph[i] = "";
		end
		glyph["A"] = ".-";    glyph["B"] = "-...";  glyph["C"] = "-.-.";  glyph["D"] = "-..";
		glyph["E"] = ".";     glyph["F"] = "..-.";  glyph["G"] = "--.";   glyph["H"] = "....";
		glyph["I"] = "..";    glyph["J"] = ".---";  glyph["K"] = "-.-";   glyph["L"] = ".-..";
		glyph["M"] = "--";    glyph["N"] = "-.";    glyph["O"] = "---";   glyph["P"] = ".--.";
		glyph["Q"] = "--.-";  glyph["R"] = ".-.";   glyph["S"] = "...";   glyph["T"] = "-";
		glyph["U"] = "..-";   glyph["V"] = "...-";  glyph["W"] = ".--";   glyph["X"] = "-..-";
		glyph["Y"] = "-.--";  glyph["Z"] = "--..";
		glyph["0"] = "-----"; glyph["1"] = ".----"; glyph["2"] = "..---"; glyph["3"] = "...--";
		glyph["4"] = "....-"; glyph["5"] = "....."; glyph["6"] = "-...."; glyph["7"] = "--...";
		glyph["8"] = "---.."; glyph["9"] = "----.";
		glyph["."] = ".-.-.-"; glyph[","] = "--..--"; glyph["?"] = "..--.."; glyph["/"] = "-..-.";
		glyph["="] = "-...-";  glyph["-"] = "-....-"; glyph[":"] = "---..."; glyph["("] = "-.--.";
		glyph[")"] = "-.--.-";
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		errors++;
	endtask

	task automatic next_element();
		string g;
		logic  dash;
		logic  loaded;
		if (elem_left == 0) begin
			loaded = 1'b0;
			while (!loaded && cursor < txt_len) begin
				g = glyph_of(txt[cursor]);
				cursor++;
				if (g.len() > 0) begin
					letter = g;
					elem_left = g.len();
					loaded = 1'b1;
				end
			end
			if (!loaded) begin
				tone_left = '0;
				gap_left = 23'd1;
				finished = 1'b1;
				return;
			end
		end
		dash = (letter[letter.len() - elem_left] == "-");
		elem_left--;
		tone_left = dash ? 23'(3 * dit_len) : 23'(dit_len);
		if (elem_left != 0) begin
			gap_left = 23'(dit_len);
		end else if (cursor < txt_len && txt[cursor] == SPACE_CHAR) begin
			gap_left = 23'(7 * dit_len);
			cursor++;
		end else begin
			gap_left = 23'(3 * dit_len);
		end
	endtask

	task automatic take_word(input req_t r, input logic [7:0] c);
		int         shape;
		int         prod;
		tone_word_t w;
		case (r)
			REQ_APPEND: begin
				if (txt_len < BUF_LEN) begin
					txt[txt_len] = c;
					txt_len++;
				end
				finished = 1'b0;
			end
			REQ_CLEAR: begin
				txt_len = 0;
				cursor = 0;
				finished = 1'b0;
			end
			REQ_TICK: begin
				if (tone_left == 0 && gap_left == 0) begin
					next_element();
				end
				shape = 0;
				prod = wave[phase[31:22]];
				phase = phase + step;
				if (tone_left != 0) begin
					tone_left--;
					if (env_pos >= RAMP_LEN) begin
						shape = 32767;
					end else begin
						shape = ramp(env_pos);
						env_pos++;
					end
				end else if (gap_left != 0) begin
					gap_left--;
					if (env_pos != 0) begin
						shape = ramp(env_pos);
						env_pos--;
					end
				end
				prod = prod * shape;
				w.smp = 16'(prod >>> 15);
				w.done = finished;
				tone_fifo.push_back(w);
			end
			default: ;
		endcase
	endtask

	initial begin
		errors = 0;
		pending = 0;
		samples_checked = 0;
		words_seen = 0;
	end

	always @(posedge clk) begin
		tone_word_t w;
		if (!arst_n) begin
			tone_fifo.delete();
			dit_len = 20'd2880;
			step = 32'd62634975;
			phase = '0;
			env_pos = '0;
			tone_left = '0;
			gap_left = '0;
			elem_left = 0;
			txt_len = 0;
			cursor = 0;
			finished = 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_DIT) begin
					dit_len = cfg_data[19:0];
				end else begin
					step = cfg_data;
				end
			end
			if (s_tvalid && s_tready) begin
				words_seen++;
				take_word(req_t'(s_tuser), s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (tone_fifo.size() == 0) begin
					report("unexpected sample word", int'($signed(m_tdata[15:0])), 0);
				end else begin
					w = tone_fifo.pop_front();
					samples_checked++;
					if (m_tdata[15:0] !== w.smp) begin
						report("sample", int'($signed(m_tdata[15:0])), int'(w.smp));
					end
					if (m_tdata[16] !== w.done) begin
						report("done flag", int'(m_tdata[16]), int'(w.done));
					end
				end
			end
		end
		pending = tone_fifo.size();
	end
endmodule

FILE: test/tb_top.sv
// Top of the Morse tone keyer testbench: clock, reset, stimulus and verdict.
// Depends on mtk_pkg, morse_tone_keyer_top and tb_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mtk_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [0:0]  cfg_addr;
	logic [31:0] cfg_data;

	int   errors;
	int   pending;
	int   samples_checked;
	int   words_seen;
	int   tx_idle;
	int   rx_idle;
	int   words_sent;
	int   quiet_cycles;
	logic hold_req;

	morse_tone_keyer_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	tb_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .samples_checked(samples_checked),
		.words_seen(words_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic put_word(input req_t r, input logic [7:0] c);
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_keying(input logic [19:0] dit, input logic [31:0] inc);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= CFG_DIT;
		cfg_data <= {12'd0, dit};
		@(posedge clk);
		cfg_addr <= CFG_STEP;
		cfg_data <= inc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] any_char();
		string punct;
		int    r;
		punct = ".,?/=-:()";
		r = $urandom_range(99);
		if (r < 25) begin
			return 8'("A" + $urandom_range(25));
		end else if (r < 50) begin
			return 8'("a" + $urandom_range(25));
		end else if (r < 60) begin
			return 8'("0" + $urandom_range(9));
		end else if (r < 68) begin
			return punct[$urandom_range(punct.len() - 1)];
		end else if (r < 82) begin
			return SPACE_CHAR;
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic run_messages(input int count);
		int stop;
		stop = words_sent + count;
		while (words_sent < stop) begin
			if ($urandom_range(99) < 40) begin
				put_word(REQ_CLEAR, 8'($urandom_range(255)));
			end
			repeat ($urandom_range(1, 6)) put_word(REQ_APPEND, any_char());
			if ($urandom_range(99) < 8) begin
				put_word(REQ_SPARE, 8'($urandom_range(255)));
			end
			repeat ($urandom_range(4, 50)) put_word(REQ_TICK, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [19:0] dits[6];
		logic [31:0] incs[6];
		int          lens[6];
		string       opening;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_TICK;
		cfg_we = 1'b0;
		cfg_addr = CFG_DIT;
		cfg_data = '0;
		hold_req = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		words_sent = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_word(REQ_TICK, 8'h00);
		put_word(REQ_TICK, 8'hff);
		set_keying(20'd1, 32'hffff_ffff);
		opening = " e ";
		put_word(REQ_CLEAR, 8'h00);
		foreach (opening[i]) put_word(REQ_APPEND, opening[i]);
		put_word(REQ_APPEND, 8'hff);
		put_word(REQ_APPEND, ")");
		put_word(REQ_APPEND, "Z");
		put_word(REQ_APPEND, "0");
		put_word(REQ_APPEND, SPACE_CHAR);
		put_word(REQ_SPARE, 8'hff);
		repeat (12) put_word(REQ_TICK, 8'h00);

		dits = '{20'd1, 20'd3, 20'd2, 20'd0, 20'hfffff, 20'd1};
		incs = '{$urandom, 32'd0, $urandom, $urandom, 32'hffff_ffff, $urandom};
		lens = '{250, 250, 250, 100, 100, 300};
		for (int seg = 0; seg < 6; seg++) begin
			set_keying(dits[seg], incs[seg]);
			tx_idle = (seg < 2) ? 14 : (seg < 4) ? 82 : 0;
			rx_idle = (seg < 2) ? 82 : (seg < 4) ? 14 : 0;
			if (seg == 2) begin
				hold_req <= 1'b1;
			end
			if (seg == 5) begin
				put_word(REQ_CLEAR, 8'h00);
				repeat (260) put_word(REQ_APPEND, 8'($urandom_range(255)));
				repeat (40) put_word(REQ_TICK, 8'h00);
			end
			run_messages(lens[seg]);
		end

		drain();
		repeat (40) @(posedge clk);
		$display("Run covered %0d input words and %0d checked samples", words_seen,
			samples_checked);
		$display("over six keying settings, three idle patterns and one long output stall.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: morse_tone_keyer_top.f
hw/rtl/mtk_pkg.sv
hw/rtl/mtk_ram.sv
hw/rtl/mtk_tone.sv
hw/rtl/morse_tone_keyer_top.sv
test/tb_checker.sv
test/tb_top.sv
